FILE: rtl/evr_pkg.sv
// Shared constants and types for the Euler vector rotator.
// No dependencies; imported by every rotator module.
package evr_pkg;

    localparam int TRIG_BITS = 18;   // signed sine/cosine, 16 fraction bits
    localparam int Q_BITS    = 32;   // polynomial working width (Q30)

    localparam logic CMD_PLAIN = 1'b0;
    localparam logic CMD_SWAP  = 1'b1;

    localparam logic [Q_BITS-1:0] POLY_C0 = 32'd1686629713;
    localparam logic [Q_BITS-1:0] POLY_C1 = 32'd693598668;
    localparam logic [Q_BITS-1:0] POLY_C2 = 32'd85569306;
    localparam logic [Q_BITS-1:0] POLY_C3 = 32'd5026995;
    localparam logic [Q_BITS-1:0] POLY_C4 = 32'd172272;

    typedef logic signed [TRIG_BITS-1:0] trig_t;

    typedef struct packed {
        trig_t sin_v;
        trig_t cos_v;
    } sincos_t;

endpackage

FILE: rtl/evr_sincos.sv
// Pipelined sine/cosine of a binary angle: one quarter-wave polynomial per output.
// Depends on evr_pkg. One item per cycle with enable.
module evr_sincos import evr_pkg::*; #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output sincos_t               result
);

    localparam int NSTG = 8;

    logic [ANGLE_BITS-1:0] qtr;
    logic [ANGLE_BITS-1:0] cang;
    assign qtr  = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    assign cang = angle + qtr;

    // 0: sine lane, 1: cosine lane
    logic              neg_reg  [2][NSTG];
    logic [Q_BITS-1:0] x_reg    [2][NSTG];
    logic [Q_BITS-1:0] x2_reg   [2][NSTG];
    logic [Q_BITS-1:0] p_reg    [2][NSTG];

    function automatic logic [23:0] map_u(input logic [ANGLE_BITS-1:0] a);
        logic [23:0] r;
        r = 24'(a[ANGLE_BITS-3:0]) << (24 - ANGLE_BITS);
        if (a[ANGLE_BITS-2]) map_u = 24'(1 << 22) - r;
        else                 map_u = r;
    endfunction

    function automatic logic [Q_BITS-1:0] hstep(input logic [Q_BITS-1:0] c,
                                                input logic [Q_BITS-1:0] x2,
                                                input logic [Q_BITS-1:0] p);
        logic [63:0] prod;
        prod  = 64'(x2) * 64'(p);
        hstep = c - Q_BITS'(prod >> 30);
    endfunction

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [ANGLE_BITS-1:0] a;
        logic [63:0] x2p;
        logic [63:0] sp;
        logic [17:0] s_r;
        logic [16:0] mag;
        assign a   = (l == 0) ? angle : cang;
        assign x2p = 64'(x_reg[l][0]) * 64'(x_reg[l][0]);
        assign sp  = 64'(x_reg[l][5]) * 64'(p_reg[l][5]);
        assign s_r = 18'((34'(p_reg[l][6]) + 34'd8192) >> 14);
        assign mag = (s_r > 18'd65536) ? 17'd65536 : s_r[16:0];

        always_ff @(posedge aclk) begin
            if (en) begin
                // stage 0: quadrant fold and Q30 x
                neg_reg[l][0] <= a[ANGLE_BITS-1];
                x_reg[l][0]   <= Q_BITS'(map_u(a)) << 8;
                // stage 1: x squared
                x_reg[l][1]   <= x_reg[l][0];
                x2_reg[l][1]  <= Q_BITS'(x2p >> 30);
                neg_reg[l][1] <= neg_reg[l][0];
                // stages 2..5: Horner steps
                for (int k = 2; k < 6; k++) begin
                    x_reg[l][k]   <= x_reg[l][k-1];
                    x2_reg[l][k]  <= x2_reg[l][k-1];
                    neg_reg[l][k] <= neg_reg[l][k-1];
                end
                p_reg[l][2] <= hstep(POLY_C3, x2_reg[l][1], POLY_C4);
                p_reg[l][3] <= hstep(POLY_C2, x2_reg[l][2], p_reg[l][2]);
                p_reg[l][4] <= hstep(POLY_C1, x2_reg[l][3], p_reg[l][3]);
                p_reg[l][5] <= hstep(POLY_C0, x2_reg[l][4], p_reg[l][4]);
                // stage 6: final product
                p_reg[l][6]   <= Q_BITS'(sp >> 30);
                neg_reg[l][6] <= neg_reg[l][5];
                // stage 7: round, cap, sign
                p_reg[l][7] <= neg_reg[l][6] ? -Q_BITS'(mag) : Q_BITS'(mag);
            end
        end
    end

    assign result.sin_v = TRIG_BITS'(p_reg[0][7]);
    assign result.cos_v = TRIG_BITS'(p_reg[1][7]);

endmodule

FILE: rtl/evr_mix.sv
// One plane rotation stage pair: registered products, then sum and round.
// Depends on evr_pkg. Result rounded half up by 2^16.
module evr_mix import evr_pkg::*; #(
    parameter int W = 50
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    input  trig_t               c,
    input  trig_t               s,
    output logic signed [W-1:0] p_out,   // round((a*c - b*s)/2^16)
    output logic signed [W-1:0] q_out    // round((a*s + b*c)/2^16)
);

    localparam int PW = W + TRIG_BITS;

    logic signed [PW-1:0] ac_reg, bs_reg, as_reg, bc_reg;
    logic signed [PW:0]   p_sum, q_sum;

    assign p_sum = (PW+1)'(ac_reg) - (PW+1)'(bs_reg) + (PW+1)'(32768);
    assign q_sum = (PW+1)'(as_reg) + (PW+1)'(bc_reg) + (PW+1)'(32768);

    always_ff @(posedge aclk) begin
        if (en) begin
            ac_reg <= PW'(a) * PW'(c);
            bs_reg <= PW'(b) * PW'(s);
            as_reg <= PW'(a) * PW'(s);
            bc_reg <= PW'(b) * PW'(c);
            p_out  <= W'(p_sum >>> 16);
            q_out  <= W'(q_sum >>> 16);
        end
    end

endmodule

FILE: rtl/euler_vector_rotator_unit.sv
// Top level of the Euler vector rotator: trig units, three rotation stages, clip.
// Depends on evr_pkg, evr_sincos and evr_mix.
//
//  channel | ports               | direction | item
//  input   | s_valid / s_ready   | in        | command, vector, three angles
//  result  | m_valid / m_ready   | out       | rotated vector, saturated flag
//
// One item per cycle; 15 register stages (8 for sine/cosine, 2 per rotation,
// one for clipping), the first at the accepting edge. Reset clears only the
// valid bits. The whole pipeline advances when the output register is empty
// or being taken, so a stall holds every stage in place.
module euler_vector_rotator_unit import evr_pkg::*; #(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_command,
    input  logic signed [COORD_BITS-1:0] s_vec_x,
    input  logic signed [COORD_BITS-1:0] s_vec_y,
    input  logic signed [COORD_BITS-1:0] s_vec_z,
    input  logic signed [ANGLE_BITS-1:0] s_roll_angle,
    input  logic signed [ANGLE_BITS-1:0] s_yaw_angle,
    input  logic signed [ANGLE_BITS-1:0] s_pitch_angle,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] m_out_x,
    output logic signed [COORD_BITS-1:0] m_out_y,
    output logic signed [COORD_BITS-1:0] m_out_z,
    output logic                         m_saturated
);

    localparam int W    = COORD_BITS + 4;   // growth over three rotations
    localparam int TLAT = 8;
    localparam int LAT  = TLAT + 6;

    logic en;
    logic [LAT-1:0] vld_reg;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    sincos_t roll_sc, yaw_sc, pitch_sc;
    evr_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
        .aclk(aclk), .en(en), .angle(s_roll_angle), .result(roll_sc));
    evr_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .aclk(aclk), .en(en), .angle(s_yaw_angle), .result(yaw_sc));
    evr_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .aclk(aclk), .en(en), .angle(s_pitch_angle), .result(pitch_sc));

    // delay the vector alongside the trig pipeline (swap applied at entry)
    logic signed [COORD_BITS-1:0] dx_reg [TLAT];
    logic signed [COORD_BITS-1:0] dy_reg [TLAT];
    logic signed [COORD_BITS-1:0] dz_reg [TLAT];
    trig_t sy_reg [4];
    trig_t cy_reg [4];
    trig_t sp_reg [2];
    trig_t cp_reg [2];
    logic signed [W-1:0] x2_reg [2];

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg[0] <= s_vec_x;
            dy_reg[0] <= (s_command == CMD_SWAP) ? s_vec_z : s_vec_y;
            dz_reg[0] <= (s_command == CMD_SWAP) ? s_vec_y : s_vec_z;
            for (int k = 1; k < TLAT; k++) begin
                dx_reg[k] <= dx_reg[k-1];
                dy_reg[k] <= dy_reg[k-1];
                dz_reg[k] <= dz_reg[k-1];
            end
            sp_reg[0] <= pitch_sc.sin_v;  cp_reg[0] <= pitch_sc.cos_v;
            sp_reg[1] <= sp_reg[0];       cp_reg[1] <= cp_reg[0];
            sy_reg[0] <= yaw_sc.sin_v;    cy_reg[0] <= yaw_sc.cos_v;
            for (int k = 1; k < 4; k++) begin
                sy_reg[k] <= sy_reg[k-1];
                cy_reg[k] <= cy_reg[k-1];
            end
            x2_reg[0] <= W'(dx_reg[TLAT-1]);
            x2_reg[1] <= x2_reg[0];
        end
    end

    // roll: y' = y*cr - z*sr ; z' = y*sr + z*cr
    logic signed [W-1:0] y1, z1;
    evr_mix #(.W(W)) u_roll_mix (
        .aclk(aclk), .en(en),
        .a(W'(dy_reg[TLAT-1])), .b(W'(dz_reg[TLAT-1])),
        .c(roll_sc.cos_v), .s(roll_sc.sin_v), .p_out(y1), .q_out(z1));

    // pitch: x' = x*cp - y*sp ; y' = x*sp + y*cp
    logic signed [W-1:0] x2, y2, z1d_reg [2];
    always_ff @(posedge aclk) begin
        if (en) begin
            z1d_reg[0] <= z1;
            z1d_reg[1] <= z1d_reg[0];
        end
    end
    evr_mix #(.W(W)) u_pitch_mix (
        .aclk(aclk), .en(en), .a(x2_reg[1]), .b(y1),
        .c(cp_reg[1]), .s(sp_reg[1]), .p_out(x2), .q_out(y2));

    // yaw: x' = x*cy + z*sy ; z' = z*cy - x*sy, i.e. (z, x) by angle +sy
    logic signed [W-1:0] z3, x3, y2d_reg [2];
    always_ff @(posedge aclk) begin
        if (en) begin
            y2d_reg[0] <= y2;
            y2d_reg[1] <= y2d_reg[0];
        end
    end
    evr_mix #(.W(W)) u_yaw_mix (
        .aclk(aclk), .en(en), .a(z1d_reg[1]), .b(x2),
        .c(cy_reg[3]), .s(sy_reg[3]), .p_out(z3), .q_out(x3));

    localparam logic signed [W-1:0] HI = W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [W-1:0] LO = -HI - W'(1);

    function automatic logic [COORD_BITS:0] clip(input logic signed [W-1:0] v);
        if (v > HI)      clip = {1'b1, HI[COORD_BITS-1:0]};
        else if (v < LO) clip = {1'b1, LO[COORD_BITS-1:0]};
        else             clip = {1'b0, v[COORD_BITS-1:0]};
    endfunction

    logic [COORD_BITS:0] cx, cy, cz;
    assign cx = clip(x3);
    assign cy = clip(z3);
    assign cz = clip(y2d_reg[1]);

    always_ff @(posedge aclk) begin
        if (en) begin
            m_out_x     <= cx[COORD_BITS-1:0];
            m_out_y     <= cy[COORD_BITS-1:0];
            m_out_z     <= cz[COORD_BITS-1:0];
            m_saturated <= cx[COORD_BITS] | cy[COORD_BITS] | cz[COORD_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            m_valid <= 1'b0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
            m_valid <= vld_reg[LAT-1];
        end
    end

endmodule
